@@ hw/rtl/mssr_pkg.sv @@
// ----------------------------------------------------------------------------
// mssr_pkg - shared types, constants and glyph lookup
// Segment tables, frame request type and queue read-side bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mssr_pkg;

    localparam int          NUM_DIGITS_DEF = 4;
    localparam int          FRAME_BITS     = 16;
    localparam int          CNT_W          = 4;
    localparam int          DIGIT_W        = 2;
    localparam int          CHAR_W         = 8;
    localparam int          QUEUE_DEPTH    = 2;

    localparam logic        REQ_STORE      = 1'b0;
    localparam logic        REQ_TICK       = 1'b1;

    localparam logic [7:0]  BLANK_PATTERN  = 8'hFF;
    localparam logic [7:0]  SELECT_BASE    = 8'hF0;
    localparam logic [7:0]  SPACE_CHAR     = 8'h20;
    localparam logic [7:0]  NUL_CHAR       = 8'h00;
    localparam logic [7:0]  CHAR_ZERO      = 8'h30;
    localparam logic [7:0]  CHAR_NINE      = 8'h39;
    localparam logic [7:0]  CHAR_UP_A      = 8'h41;
    localparam logic [7:0]  CHAR_UP_Z      = 8'h5A;
    localparam logic [7:0]  CHAR_LO_A      = 8'h61;
    localparam logic [7:0]  CHAR_LO_Z      = 8'h7A;

    localparam logic [7:0] DIGIT_PAT [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    localparam logic [7:0] LETTER_PAT [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hCF, 8'hE1,
        8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h4A, 8'hCC, 8'h92, 8'h87,
        8'hC1, 8'hC1, 8'hD5, 8'h89, 8'h91, 8'hA4
    };

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [DIGIT_W-1:0]    digit;
    } t_frame_req;

    typedef struct packed {
        logic       valid;
        t_frame_req data;
    } t_q_rd;

    // active-low segment pattern for one ASCII character
    function automatic logic [7:0] glyph(input logic [7:0] c);
        logic [7:0] off_d;
        logic [7:0] off_u;
        logic [7:0] off_l;
        off_d = c - CHAR_ZERO;
        off_u = c - CHAR_UP_A;
        off_l = c - CHAR_LO_A;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            glyph = DIGIT_PAT[off_d[3:0]];
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            glyph = LETTER_PAT[off_u[4:0]];
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            glyph = LETTER_PAT[off_l[4:0]];
        end else begin
            glyph = BLANK_PATTERN;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/multiplexed_seven_segment_refresher_unit.sv @@
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_refresher_unit - 7-segment refresh serializer
// Stores characters per digit and emits a 16-bit segment/select frame per tick.
// ----------------------------------------------------------------------------
// Path: with queue and serializer idle, an accepted tick is written into the frame
//   queue, then loaded into the serializer, which then presents its first bit.
// Throughput: one serial bit per cycle while the receiver does not stall; a tick
//   occupies the serializer for its whole 16-bit frame. Stores give no output.
//   The two-entry frame queue sets how far intake runs ahead.
// Reset: buffer reads all spaces, digit counter at zero, queue and serializer empty.
`default_nettype none

module multiplexed_seven_segment_refresher_unit #(
    parameter int NUM_DIGITS = mssr_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_req_type,
    input  wire logic [1:0]                     i_position,
    input  wire logic [mssr_pkg::CHAR_W-1:0]    i_character,
    // serial bit channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_serial_bit,
    output logic [mssr_pkg::CNT_W-1:0]          o_bit_number,
    output logic [mssr_pkg::DIGIT_W-1:0]        o_active_digit,
    output logic                                o_latch_now
);

    // front -> queue
    logic                  push;
    mssr_pkg::t_frame_req  push_data;
    logic                  q_full;
    // queue -> back
    mssr_pkg::t_q_rd       q_rd;
    logic                  pop;

    // Front: stores update the buffer at once; a tick snapshots glyph and
    // select byte into a frame request, so later stores cannot disturb it.
    mssr_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_character (i_character),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Queue: lets the front keep accepting while a frame shifts out.
    mssr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_rd        (q_rd)
    );

    // Back: registered serializer; next frame loads right after latch bit.
    mssr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd           (q_rd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_serial_bit   (o_serial_bit),
        .o_bit_number   (o_bit_number),
        .o_active_digit (o_active_digit),
        .o_latch_now    (o_latch_now)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mssr_front.sv @@
// ----------------------------------------------------------------------------
// mssr_front - request intake
// Holds the character buffer and digit counter; builds frames for ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module mssr_front #(
    parameter int NUM_DIGITS = mssr_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_req_type,
    input  wire logic [1:0]                     i_position,
    input  wire logic [mssr_pkg::CHAR_W-1:0]    i_character,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output mssr_pkg::t_frame_req                o_push_data
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [mssr_pkg::CHAR_W-1:0]  r_buf [NUM_DIGITS];
    logic [mssr_pkg::DIGIT_W-1:0] r_digit;
    logic [mssr_pkg::DIGIT_W-1:0] n_digit;
    logic                         accept;
    logic                         store_en;
    logic [mssr_pkg::CHAR_W-1:0]  store_char;
    logic [7:0]                   pattern;
    logic [7:0]                   select;

    assign o_stall    = i_q_full;
    assign accept     = i_valid && !i_q_full;
    assign store_en   = accept && (i_req_type == mssr_pkg::REQ_STORE)
                        && ({30'd0, i_position} < NUM_DIGITS);
    assign store_char = (i_character == mssr_pkg::NUL_CHAR) ? mssr_pkg::SPACE_CHAR
                                                             : i_character;

    assign pattern = mssr_pkg::glyph(r_buf[r_digit[IDX_W-1:0]]);
    assign select  = mssr_pkg::SELECT_BASE | (8'd1 << r_digit);

    assign o_push            = accept && (i_req_type == mssr_pkg::REQ_TICK);
    assign o_push_data.frame = {pattern, select};
    assign o_push_data.digit = r_digit;

    assign n_digit = (r_digit == mssr_pkg::DIGIT_W'(NUM_DIGITS - 1))
                     ? '0 : r_digit + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_buf[i] <= mssr_pkg::SPACE_CHAR;
            end
            r_digit <= '0;
        end else begin
            if (store_en) begin
                r_buf[i_position[IDX_W-1:0]] <= store_char;
            end
            if (o_push) begin
                r_digit <= n_digit;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mssr_queue.sv @@
// ----------------------------------------------------------------------------
// mssr_queue - frame request queue
// Two-entry FIFO that decouples intake from the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module mssr_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire mssr_pkg::t_frame_req   i_push_data,
    output logic                        o_full,
    input  wire logic                   i_pop,
    output mssr_pkg::t_q_rd             o_rd
);

    localparam int PTR_W = $clog2(mssr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mssr_pkg::QUEUE_DEPTH + 1);

    mssr_pkg::t_frame_req r_mem [mssr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 do_pop;

    assign o_full     = (r_count == CNT_W'(mssr_pkg::QUEUE_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.data  = r_mem[r_rd_ptr];
    assign do_pop     = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(mssr_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not reduce count");

endmodule

`default_nettype wire

@@ hw/rtl/mssr_back.sv @@
// ----------------------------------------------------------------------------
// mssr_back - frame serializer
// Shifts each queued frame out MSB first, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mssr_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mssr_pkg::t_q_rd                i_rd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_serial_bit,
    output logic [mssr_pkg::CNT_W-1:0]          o_bit_number,
    output logic [mssr_pkg::DIGIT_W-1:0]        o_active_digit,
    output logic                                o_latch_now
);

    localparam logic [mssr_pkg::CNT_W-1:0] LAST_BIT =
        mssr_pkg::CNT_W'(mssr_pkg::FRAME_BITS - 1);

    logic                              r_busy;
    logic [mssr_pkg::FRAME_BITS-1:0]   r_shift;
    logic [mssr_pkg::CNT_W-1:0]        r_cnt;
    logic [mssr_pkg::DIGIT_W-1:0]      r_digit;
    logic                              out_acc;
    logic                              last;

    assign out_acc = r_busy && !i_stall;
    assign last    = (r_cnt == LAST_BIT);
    // load when idle, or right behind the last bit of the current frame
    assign o_pop   = i_rd.valid && (!r_busy || (out_acc && last));

    assign o_valid        = r_busy;
    assign o_serial_bit   = r_shift[mssr_pkg::FRAME_BITS-1];
    assign o_bit_number   = r_cnt;
    assign o_active_digit = r_digit;
    assign o_latch_now    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_shift <= i_rd.data.frame;
                r_digit <= i_rd.data.digit;
            end else if (out_acc) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_shift <= {r_shift[mssr_pkg::FRAME_BITS-2:0], 1'b0};
                end
            end
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_stall) |=> (r_busy && $stable(r_cnt) && $stable(r_shift)))
        else $error("stalled bit changed");

    a_digit_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !last) |=> (r_busy && $stable(r_digit)))
        else $error("digit changed inside a frame");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && last && !i_rd.valid) |=> !r_busy)
        else $error("serializer stayed busy after frame");

endmodule

`default_nettype wire

@@ sim/mssr_frame_checker.sv @@
// ----------------------------------------------------------------------------
// mssr_frame_checker - scoreboard for the seven-segment refresh serializer
// Tracks accepted store and tick requests, predicts each 16-bit serial frame
// and compares every accepted serial bit against the oldest prediction.
// ----------------------------------------------------------------------------
module mssr_frame_checker #(
    parameter int NUM_DIGITS = mssr_pkg::NUM_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_req_type,
    input  logic [1:0]  i_position,
    input  logic [7:0]  i_character,
    // serial bit channel
    input  logic        i_bit_valid,
    input  logic        i_bit_stall,
    input  logic        i_serial_bit,
    input  logic [3:0]  i_bit_number,
    input  logic [1:0]  i_active_digit,
    input  logic        i_latch_now,
    // status
    output int          o_err_count,
    output int          o_pending,
    output int          o_store_count,
    output int          o_tick_count,
    output int          o_bit_count
);
    import mssr_pkg::*;

    // active-low segment patterns
    localparam logic [7:0] NUMERAL_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam logic [7:0] ALPHA_SEGS [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hCF, 8'hE1,
        8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h4A, 8'hCC, 8'h92, 8'h87,
        8'hC1, 8'hC1, 8'hD5, 8'h89, 8'h91, 8'hA4
    };

    typedef struct packed {
        logic       serial_bit;
        logic [3:0] bit_number;
        logic [1:0] active_digit;
        logic       latch_now;
    } serial_bit_t;

    logic [7:0]   shown_chars [4];
    logic [1:0]   scan_digit;
    serial_bit_t  expected_bits [$];

    function automatic logic [7:0] segments_for(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return NUMERAL_SEGS[c - CHAR_ZERO];
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            return ALPHA_SEGS[c - CHAR_UP_A];
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            return ALPHA_SEGS[c - CHAR_LO_A];
        end
        return BLANK_PATTERN;
    endfunction

    initial begin
        o_err_count   = 0;
        o_pending     = 0;
        o_store_count = 0;
        o_tick_count  = 0;
        o_bit_count   = 0;
    end

    always @(posedge i_clk) begin : watch
        serial_bit_t             want;
        serial_bit_t             got;
        logic [FRAME_BITS-1:0]   frame;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) shown_chars[i] = SPACE_CHAR;
            scan_digit = '0;
            expected_bits.delete();
        end else begin
            // output side first: a new tick cannot reach the output this cycle
            if (i_bit_valid && !i_bit_stall) begin
                got = '{i_serial_bit, i_bit_number, i_active_digit, i_latch_now};
                o_bit_count++;
                if (expected_bits.size() == 0) begin
                    $display("%0t: serial bit with nothing expected: bit=%0d num=%0d dig=%0d latch=%0d",
                             $time, got.serial_bit, got.bit_number, got.active_digit,
                             got.latch_now);
                    o_err_count++;
                end else begin
                    want = expected_bits.pop_front();
                    if (got.serial_bit !== want.serial_bit) begin
                        $display("%0t: serial_bit mismatch: expected %0d, actual %0d",
                                 $time, want.serial_bit, got.serial_bit);
                        o_err_count++;
                    end
                    if (got.bit_number !== want.bit_number) begin
                        $display("%0t: bit_number mismatch: expected %0d, actual %0d",
                                 $time, want.bit_number, got.bit_number);
                        o_err_count++;
                    end
                    if (got.active_digit !== want.active_digit) begin
                        $display("%0t: active_digit mismatch: expected %0d, actual %0d",
                                 $time, want.active_digit, got.active_digit);
                        o_err_count++;
                    end
                    if (got.latch_now !== want.latch_now) begin
                        $display("%0t: latch_now mismatch: expected %0d, actual %0d",
                                 $time, want.latch_now, got.latch_now);
                        o_err_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_req_type == REQ_TICK) begin
                    o_tick_count++;
                    frame = {segments_for(shown_chars[scan_digit]),
                             SELECT_BASE | (8'd1 << scan_digit)};
                    for (int k = 0; k < FRAME_BITS; k++) begin
                        want.serial_bit   = frame[FRAME_BITS-1-k];
                        want.bit_number   = 4'(k);
                        want.active_digit = scan_digit;
                        want.latch_now    = (k == FRAME_BITS - 1);
                        expected_bits.push_back(want);
                    end
                    scan_digit = 2'((int'(scan_digit) + 1) % NUM_DIGITS);
                end else begin
                    o_store_count++;
                    // out-of-range positions are dropped
                    if (int'(i_position) < NUM_DIGITS) begin
                        shown_chars[i_position] = (i_character == NUL_CHAR) ? SPACE_CHAR
                                                                            : i_character;
                    end
                end
            end
        end
        o_pending = expected_bits.size();
    end

endmodule

@@ sim/multiplexed_seven_segment_refresher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_refresher_unit_tb - top of the refresher testbench
// Drives store and refresh-tick requests with random gaps and output stalls,
// including one long receiver hold-off; a checker predicts every serial bit.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_refresher_unit_tb;
    import mssr_pkg::*;

    localparam int DIGITS       = NUM_DIGITS_DEF;
    localparam int RANDOM_REQS  = 300;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int PRESSURE_REQS = 12;   // ticks pushed during the hold-off
    localparam int DRAIN_CYCLES = 20;    // settle time after the last predicted bit

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_req_type  = REQ_STORE;
    logic [1:0]  i_position  = '0;
    logic [7:0]  i_character = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_serial_bit;
    logic [3:0]  o_bit_number;
    logic [1:0]  o_active_digit;
    logic        o_latch_now;

    int err_count;
    int pending_bits;
    int store_count;
    int tick_count;
    int bit_count;

    // knobs shared between the stimulus and the receiver process
    bit tx_quiet  = 1'b0;   // sender offers back to back
    bit rx_quiet  = 1'b0;   // receiver never stalls
    bit hold_off  = 1'b0;   // request one long receiver stall

    multiplexed_seven_segment_refresher_unit #(
        .NUM_DIGITS     (DIGITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_character    (i_character),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_serial_bit   (o_serial_bit),
        .o_bit_number   (o_bit_number),
        .o_active_digit (o_active_digit),
        .o_latch_now    (o_latch_now)
    );

    mssr_frame_checker #(
        .NUM_DIGITS     (DIGITS)
    ) frame_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_character    (i_character),
        .i_bit_valid    (o_valid),
        .i_bit_stall    (i_stall),
        .i_serial_bit   (o_serial_bit),
        .i_bit_number   (o_bit_number),
        .i_active_digit (o_active_digit),
        .i_latch_now    (o_latch_now),
        .o_err_count    (err_count),
        .o_pending      (pending_bits),
        .o_store_count  (store_count),
        .o_tick_count   (tick_count),
        .o_bit_count    (bit_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet)  return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Character mix: plenty of digits and letters so most frames light up,
    // the rest anything from NUL to 0xFF.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 6))
            0:       return CHAR_ZERO + 8'($urandom_range(0, 9));
            1:       return CHAR_UP_A + 8'($urandom_range(0, 25));
            2:       return CHAR_LO_A + 8'($urandom_range(0, 25));
            3:       return NUL_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one request after a random gap and hold it until accepted.
    // Valid is only dropped when a gap follows, so it is never lowered
    // and raised in the same step.
    task automatic send_req(input logic kind, input logic [1:0] pos, input logic [7:0] ch);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_position  <= pos;
        i_character <= ch;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_store(input logic [1:0] pos, input logic [7:0] ch);
        send_req(REQ_STORE, pos, ch);
    endtask

    // position and character ride along with random junk on a tick;
    // the block must ignore them
    task automatic send_tick();
        send_req(REQ_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stall runs, with a single long hold-off on request.
    initial begin : receiver
        bit stall_val;
        int run_len;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                stall_val = 1'b1;
                run_len   = HOLD_CYCLES;
                hold_off  = 1'b0;
            end else if (rx_quiet) begin
                stall_val = 1'b0;
                run_len   = 1;
            end else begin
                stall_val = ($urandom_range(0, 2) == 0);
                run_len   = pick_gap(1'b0) + 1;
            end
            @(negedge i_clk);
            i_stall <= stall_val;
            repeat (run_len - 1) @(negedge i_clk);
        end
    end

    // Watchdog: well beyond the slowest legal run (every request a tick,
    // every bit held by the longest random receiver stall).
    initial begin
        #8_000_000;
        $display("Timeout waiting for serial bits");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] edge_chars [12];
        edge_chars = '{CHAR_ZERO, CHAR_NINE, CHAR_UP_A, CHAR_LO_Z,
                       NUL_CHAR, 8'hFF, CHAR_UP_Z, CHAR_LO_A,
                       8'h40, 8'h7B, 8'h2F, 8'h3A};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a tick on the reset buffer (spaces, all segments off),
        // then three rounds of four stores and four ticks. Covers the table
        // ends, NUL stored as space, top-bit characters, and the neighbors
        // just outside the digit range, just below A and just above z.
        send_tick();
        for (int round = 0; round < 3; round++) begin
            for (int p = 0; p < 4; p++) send_store(2'(p), edge_chars[round * 4 + p]);
            repeat (4) send_tick();
        end

        // Random part, with a pressure phase and a quiet stretch inside.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 120) begin
                // receiver holds off while ticks keep coming: the frame
                // queue fills and the request side must stall
                hold_off = 1'b1;
                tx_quiet = 1'b1;
                repeat (PRESSURE_REQS) send_tick();
                tx_quiet = 1'b0;
            end
            if (n == 200) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            if (n == 240) begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            if ($urandom_range(0, 99) < 45) begin
                send_tick();
            end else begin
                send_store(2'($urandom_range(0, 3)), pick_char());
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain: wait for every predicted bit, then a short settle
        wait (pending_bits == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d store requests and %0d refresh ticks; %0d serial bits compared.",
                 store_count, tick_count, bit_count);
        $display("Included a %0d-cycle receiver hold-off with back-to-back ticks queued.",
                 HOLD_CYCLES);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
